// ===== rtl/core/ibs_pkg.sv =====
// Shared constants, codes and types of the indexed byte stack.
`default_nettype none
package ibs_pkg;

   localparam int DEFAULT_DEPTH = 64;

   localparam int FUNC_W = 3;
   localparam int VAL_W  = 8;
   localparam int POS_W  = 6;
   localparam int ST_W   = 2;
   localparam int CNT_W  = 7;

   localparam logic [FUNC_W-1:0] F_PUSH   = 3'd0;
   localparam logic [FUNC_W-1:0] F_POP    = 3'd1;
   localparam logic [FUNC_W-1:0] F_READ   = 3'd2;
   localparam logic [FUNC_W-1:0] F_FIND   = 3'd3;
   localparam logic [FUNC_W-1:0] F_REMOVE = 3'd4;
   localparam logic [FUNC_W-1:0] F_INSERT = 3'd5;
   localparam logic [FUNC_W-1:0] F_WRITE  = 3'd6;

   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

   typedef struct packed {
      logic [VAL_W-1:0] out_value;
      logic [POS_W-1:0] out_position;
      logic [ST_W-1:0]  status;
      logic [CNT_W-1:0] count;
   } res_type;

endpackage
`default_nettype wire

// ===== rtl/core/ibs_req_if.sv =====
// Request channel of the indexed byte stack.
`default_nettype none
interface ibs_req_if;
   logic                       valid;
   logic                       ready;
   logic [ibs_pkg::FUNC_W-1:0] func;
   logic [ibs_pkg::VAL_W-1:0]  item_value;
   logic [ibs_pkg::POS_W-1:0]  position;

   modport source (output valid, output func, output item_value, output position,
                   input ready);
   modport sink (input valid, input func, input item_value, input position,
                 output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ibs_rsp_if.sv =====
// Response channel of the indexed byte stack.
`default_nettype none
interface ibs_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [ibs_pkg::VAL_W-1:0] out_value;
   logic [ibs_pkg::POS_W-1:0] out_position;
   logic [ibs_pkg::ST_W-1:0]  status;
   logic [ibs_pkg::CNT_W-1:0] count;

   modport source (output valid, output out_value, output out_position,
                   output status, output count, input ready);
   modport sink (input valid, input out_value, input out_position,
                 input status, input count, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ibs_engine.sv =====
// Sequencer and entry memory of the indexed byte stack.
`default_nettype none
module ibs_engine #(
   parameter int DEPTH = ibs_pkg::DEFAULT_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [ibs_pkg::FUNC_W-1:0] func,
   input  logic [ibs_pkg::VAL_W-1:0]  item_value,
   input  logic [ibs_pkg::POS_W-1:0]  position,
   output logic                       res_valid,
   input  logic                       res_ready,
   output ibs_pkg::res_type           res
);
   import ibs_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > POS_W) ? CW : POS_W;
   localparam int YW = (CW > CNT_W) ? CW : CNT_W;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DECODE   = 3'd1;
   localparam logic [2:0] S_RDWAIT   = 3'd2;
   localparam logic [2:0] S_FIND     = 3'd3;
   localparam logic [2:0] S_REMOVE   = 3'd4;
   localparam logic [2:0] S_INSERT   = 3'd5;
   localparam logic [2:0] S_INS_LAST = 3'd6;
   localparam logic [2:0] S_DONE     = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     cur_ff, cur_in;
   logic              first_ff, first_in;
   logic [FUNC_W-1:0] op_ff, op_in;
   logic [VAL_W-1:0]  val_ff, val_in;
   logic [XW-1:0]     pos_ff, pos_in;
   logic [VAL_W-1:0]  res_val_ff, res_val_in;
   logic [POS_W-1:0]  res_pos_ff, res_pos_in;
   logic [ST_W-1:0]   res_st_ff, res_st_in;

   logic [VAL_W-1:0]  mem_ff [DEPTH];
   logic [VAL_W-1:0]  rd_data_ff;
   logic              rd_en, wr_en;
   logic [AW-1:0]     rd_addr, wr_addr;
   logic [VAL_W-1:0]  wr_data;

   logic [CW-1:0]     cnt_m1;
   logic [AW-1:0]     top_addr, pos_addr;
   logic [YW-1:0]     cnt_y;
   logic              empty, full, in_range, push_path;

   function automatic logic [POS_W-1:0] to_pos(input logic [AW-1:0] a);
      logic [XW-1:0] t;
      t = XW'(a);
      return t[POS_W-1:0];
   endfunction

   assign cnt_m1    = count_ff - CW'(1);
   assign top_addr  = cnt_m1[AW-1:0];
   assign pos_addr  = pos_ff[AW-1:0];
   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CW'(DEPTH));
   assign in_range  = (pos_ff < XW'(count_ff));
   assign push_path = (op_ff == F_PUSH) || ((op_ff == F_INSERT) && !in_range);
   assign cnt_y     = YW'(count_ff);

   assign req_ready        = (state_ff == S_IDLE);
   assign res_valid        = (state_ff == S_DONE);
   assign res.out_value    = res_val_ff;
   assign res.out_position = res_pos_ff;
   assign res.status       = res_st_ff;
   assign res.count        = cnt_y[CNT_W-1:0];

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      cur_in     = cur_ff;
      first_in   = first_ff;
      op_in      = op_ff;
      val_in     = val_ff;
      pos_in     = pos_ff;
      res_val_in = res_val_ff;
      res_pos_in = res_pos_ff;
      res_st_in  = res_st_ff;
      rd_en      = 1'b0;
      rd_addr    = '0;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = val_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = func;
               val_in   = item_value;
               pos_in   = XW'(position);
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_val_in = '0;
            res_pos_in = '0;
            res_st_in  = ST_OK;
            state_in   = S_DONE;
            if (push_path) begin
               if (full) begin
                  res_st_in = ST_FULL;
               end else begin
                  wr_en      = 1'b1;
                  wr_addr    = count_ff[AW-1:0];
                  res_pos_in = to_pos(count_ff[AW-1:0]);
                  count_in   = count_ff + CW'(1);
               end
            end else begin
               case (op_ff)
                  F_POP: begin
                     if (empty) begin
                        res_st_in = ST_EMPTY;
                     end else begin
                        rd_en      = 1'b1;
                        rd_addr    = top_addr;
                        count_in   = cnt_m1;
                        res_pos_in = to_pos(top_addr);
                        state_in   = S_RDWAIT;
                     end
                  end
                  F_READ: begin
                     if (!in_range) begin
                        res_st_in = ST_RANGE;
                     end else begin
                        rd_en      = 1'b1;
                        rd_addr    = pos_addr;
                        res_pos_in = to_pos(pos_addr);
                        state_in   = S_RDWAIT;
                     end
                  end
                  F_FIND: begin
                     if (empty) begin
                        res_st_in = ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = top_addr;
                        cur_in   = top_addr;
                        state_in = S_FIND;
                     end
                  end
                  F_REMOVE: begin
                     if (empty) begin
                        res_st_in = ST_EMPTY;
                     end else if (!in_range) begin
                        res_st_in = ST_RANGE;
                     end else begin
                        rd_en      = 1'b1;
                        rd_addr    = pos_addr;
                        cur_in     = pos_addr;
                        first_in   = 1'b1;
                        res_pos_in = to_pos(pos_addr);
                        state_in   = S_REMOVE;
                     end
                  end
                  F_INSERT: begin
                     if (full) begin
                        res_st_in = ST_FULL;
                     end else begin
                        rd_en      = 1'b1;
                        rd_addr    = top_addr;
                        cur_in     = top_addr;
                        res_pos_in = to_pos(pos_addr);
                        state_in   = S_INSERT;
                     end
                  end
                  F_WRITE: begin
                     if (!in_range) begin
                        res_st_in = ST_RANGE;
                     end else begin
                        wr_en      = 1'b1;
                        wr_addr    = pos_addr;
                        res_pos_in = to_pos(pos_addr);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RDWAIT: begin
            res_val_in = rd_data_ff;
            state_in   = S_DONE;
         end
         S_FIND: begin
            // The read data always belongs to the entry at cur_ff; the scan
            // walks downward one entry per cycle.
            if (rd_data_ff == val_ff) begin
               res_val_in = val_ff;
               res_pos_in = to_pos(cur_ff);
               res_st_in  = ST_OK;
               state_in   = S_DONE;
            end else if (cur_ff == '0) begin
               res_st_in = ST_EMPTY;
               state_in  = S_DONE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = cur_ff - AW'(1);
               cur_in  = cur_ff - AW'(1);
            end
         end
         S_REMOVE: begin
            if (first_ff) begin
               res_val_in = rd_data_ff;
            end else begin
               wr_en   = 1'b1;
               wr_addr = cur_ff - AW'(1);
               wr_data = rd_data_ff;
            end
            first_in = 1'b0;
            if ((CW'(cur_ff) + CW'(1)) < count_ff) begin
               rd_en   = 1'b1;
               rd_addr = cur_ff + AW'(1);
               cur_in  = cur_ff + AW'(1);
            end else begin
               count_in = cnt_m1;
               state_in = S_DONE;
            end
         end
         S_INSERT: begin
            wr_en   = 1'b1;
            wr_addr = cur_ff + AW'(1);
            wr_data = rd_data_ff;
            if (cur_ff == pos_addr) begin
               state_in = S_INS_LAST;
            end else begin
               rd_en   = 1'b1;
               rd_addr = cur_ff - AW'(1);
               cur_in  = cur_ff - AW'(1);
            end
         end
         S_INS_LAST: begin
            wr_en    = 1'b1;
            wr_addr  = pos_addr;
            wr_data  = val_ff;
            count_in = count_ff + CW'(1);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      first_ff   <= first_in;
      op_ff      <= op_in;
      val_ff     <= val_in;
      pos_ff     <= pos_in;
      res_val_ff <= res_val_in;
      res_pos_ff <= res_pos_in;
      res_st_ff  <= res_st_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count exceeds depth");

   a_done_release: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && res_ready |=> (state_ff == S_IDLE))
      else $error("sequencer did not return to idle after delivering a word");

   a_find_in_stack: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIND) |-> (CW'(cur_ff) < count_ff))
      else $error("find scan left the occupied entries");

   a_remove_in_stack: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REMOVE) |-> (CW'(cur_ff) < count_ff))
      else $error("remove shift left the occupied entries");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INSERT) |-> (count_ff < CW'(DEPTH)))
      else $error("insert shift started on a full stack");

endmodule
`default_nettype wire

// ===== rtl/core/ibs_out_reg.sv =====
// Output register that holds one response word until the sink takes it.
`default_nettype none
module ibs_out_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  ibs_pkg::res_type in_data,
   ibs_rsp_if.source        rsp_bus
);
   import ibs_pkg::*;

   logic    valid_ff;
   res_type data_ff;

   assign in_ready             = !valid_ff || rsp_bus.ready;
   assign rsp_bus.valid        = valid_ff;
   assign rsp_bus.out_value    = data_ff.out_value;
   assign rsp_bus.out_position = data_ff.out_position;
   assign rsp_bus.status       = data_ff.status;
   assign rsp_bus.count        = data_ff.count;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_valid && in_ready) begin
         valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/indexed_byte_stack_core.sv =====
// Top level of the indexed byte stack.
`default_nettype none
// A byte stack of DEPTH entries numbered from the bottom, held in one
// single-port-write, registered-read memory and driven by a sequencer that
// handles one request word at a time and returns exactly one response word.
// Push, write and every rejected or unused request go from the decode state
// straight to the response; pop and read pass through a read-wait state,
// since the memory read is registered. Find scans from the top down one
// entry per cycle until a match or the bottom entry. Remove shifts every
// entry above the index down by one, and insert shifts every entry from the
// top down to the index up by one and then writes the new value, each entry
// moved being read and written back by the memory. A finished response waits
// in an output register, so the next request is accepted while the previous
// response has not yet been taken. The entry memory needs no clearing after
// reset.
module indexed_byte_stack_core #(
   parameter int DEPTH = ibs_pkg::DEFAULT_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   ibs_req_if.sink   req_bus,
   ibs_rsp_if.source rsp_bus
);
   import ibs_pkg::*;

   logic    res_valid;
   logic    res_ready;
   res_type res;

   ibs_engine #(
      .DEPTH(DEPTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_ready  (req_bus.ready),
      .func       (req_bus.func),
      .item_value (req_bus.item_value),
      .position   (req_bus.position),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res)
   );

   ibs_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .in_valid (res_valid),
      .in_ready (res_ready),
      .in_data  (res),
      .rsp_bus  (rsp_bus)
   );

endmodule
`default_nettype wire
